/* design/ascon128_aead_engine_defines.svh */
// Assertion macros for the Ascon engine
`ifndef ASCON128_AEAD_ENGINE_DEFINES_SVH
`define ASCON128_AEAD_ENGINE_DEFINES_SVH
`ifndef SYNTH
`define ASC_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASC_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASC_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASC_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

/* design/asc_pkg.sv */
`default_nettype none
package asc_pkg;
  localparam int unsigned QueueDepth = 2;
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_AD    = 2'd1;
  localparam logic [1:0] REQ_MSG   = 2'd2;
  localparam logic [1:0] REQ_TAG   = 2'd3;
  localparam logic [1:0] KIND_MSG  = 2'd0;
  localparam logic [1:0] KIND_TAG  = 2'd1;
  localparam logic [1:0] KIND_VER  = 2'd2;
  localparam logic [0:0] CFG_KEY_HIGH = 1'd0;
  localparam logic [0:0] CFG_KEY_LOW  = 1'd1;
  localparam logic [63:0] INIT_VECTOR = 64'h80400c0600000000;

  // classified commands handed from front to back
  localparam logic [2:0] OP_START   = 3'd0;
  localparam logic [2:0] OP_AD      = 3'd1; // full AD block
  localparam logic [2:0] OP_ADLAST  = 3'd2; // last AD block
  localparam logic [2:0] OP_MSG     = 3'd3;
  localparam logic [2:0] OP_MSGLAST = 3'd4;
  localparam logic [2:0] OP_TAG     = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic        dmode;
    logic        close_ad;  // pad-only AD close before this payload
    logic        absorb;    // last AD block must be absorbed
    logic [63:0] wa;
    logic [63:0] wb;
    logic [2:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data;
    logic [3:0]  bytes;
    logic        ok;
    logic        last;
  } res_t;

  function automatic logic [63:0] top_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(n)) m[63-8*i -: 8] = 8'hff;
    end
    return m;
  endfunction

  function automatic logic [63:0] pad_bit(input logic [2:0] n);
    return 64'h80 << (7'd56 - {1'b0, n, 3'b000});
  endfunction

  function automatic logic [319:0] ascon_round(input logic [319:0] st,
                                               input logic [3:0] r);
    logic [63:0] s0, s1, s2, s3, s4, t0, t1, t2, t3, t4;
    s0 = st[319:256]; s1 = st[255:192]; s2 = st[191:128];
    s3 = st[127:64];  s4 = st[63:0];
    s2 = s2 ^ {56'd0, 4'hf - r, r};
    s0 = s0 ^ s4; s4 = s4 ^ s3; s2 = s2 ^ s1;
    t0 = ~s0 & s1; t1 = ~s1 & s2; t2 = ~s2 & s3; t3 = ~s3 & s4; t4 = ~s4 & s0;
    s0 = s0 ^ t1; s1 = s1 ^ t2; s2 = s2 ^ t3; s3 = s3 ^ t4; s4 = s4 ^ t0;
    s1 = s1 ^ s0; s0 = s0 ^ s4; s3 = s3 ^ s2; s2 = ~s2;
    s0 = s0 ^ {s0[18:0], s0[63:19]} ^ {s0[27:0], s0[63:28]};
    s1 = s1 ^ {s1[60:0], s1[63:61]} ^ {s1[38:0], s1[63:39]};
    s2 = s2 ^ {s2[0], s2[63:1]} ^ {s2[5:0], s2[63:6]};
    s3 = s3 ^ {s3[9:0], s3[63:10]} ^ {s3[16:0], s3[63:17]};
    s4 = s4 ^ {s4[6:0], s4[63:7]} ^ {s4[40:0], s4[63:41]};
    return {s0, s1, s2, s3, s4};
  endfunction
endpackage
`default_nettype wire

/* design/asc_if.sv */
`default_nettype none
interface asc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        decrypt_mode;
  logic [63:0] word_a;
  logic [63:0] word_b;
  logic [3:0]  byte_count;
  logic        last_block;
  modport source (output valid, req_type, decrypt_mode, word_a, word_b, byte_count,
                  last_block, input ready);
  modport sink (input valid, req_type, decrypt_mode, word_a, word_b, byte_count,
                last_block, output ready);
endinterface

interface asc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic [63:0] out_data;
  logic [3:0]  out_bytes;
  logic        tag_ok;
  logic        last_result;
  modport source (output valid, out_kind, out_data, out_bytes, tag_ok, last_result,
                  input ready);
  modport sink (input valid, out_kind, out_data, out_bytes, tag_ok, last_result,
                output ready);
endinterface
`default_nettype wire

/* design/asc_front.sv */
`default_nettype none
`include "ascon128_aead_engine_defines.svh"
module asc_front import asc_pkg::*; #(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  wire logic clk,
  input  wire logic rst_n,
  asc_in_if.sink    in_ch,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  wire logic cmd_pop
);
  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam logic [1:0] PH_IDLE = 2'd0, PH_AD = 2'd1, PH_MSG = 2'd2, PH_TW = 2'd3;

  cmd_t q_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r, cnt_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic seen_r, seen_nxt, dec_r, dec_nxt;
  logic push, acc;
  cmd_t c;
  logic [2:0] bc;

  assign in_ch.ready = (cnt_r != (PW+1)'(QDEPTH));
  assign acc = in_ch.valid && in_ch.ready;
  assign bc = (in_ch.byte_count > 4'd7) ? 3'd7 : in_ch.byte_count[2:0];

  // phase tracking lives here; misplaced items are dropped before the queue
  always_comb begin
    phase_nxt = phase_r; seen_nxt = seen_r; dec_nxt = dec_r; push = 1'b0;
    c = '0;
    c.dmode = in_ch.decrypt_mode; c.wa = in_ch.word_a; c.wb = in_ch.word_b; c.cnt = bc;
    unique case (in_ch.req_type)
      REQ_START: begin
        c.op = OP_START; push = 1'b1; phase_nxt = PH_AD; seen_nxt = 1'b0;
        dec_nxt = in_ch.decrypt_mode;
      end
      REQ_AD: if (phase_r == PH_AD) begin
        push = 1'b1;
        if (!in_ch.last_block) begin
          c.op = OP_AD; seen_nxt = 1'b1;
        end else begin
          c.op = OP_ADLAST; c.absorb = (bc != 3'd0) || seen_r; phase_nxt = PH_MSG;
        end
      end
      REQ_MSG: if (phase_r == PH_AD || phase_r == PH_MSG) begin
        push = 1'b1; c.dmode = dec_r;
        c.close_ad = (phase_r == PH_AD);
        c.absorb = seen_r;
        if (in_ch.last_block) begin
          c.op = OP_MSGLAST; phase_nxt = dec_r ? PH_TW : PH_IDLE;
        end else begin
          c.op = OP_MSG; phase_nxt = PH_MSG;
        end
      end
      default: if (phase_r == PH_TW) begin
        push = 1'b1; c.op = OP_TAG; phase_nxt = PH_IDLE;
      end
    endcase
  end

  assign cnt_nxt = cnt_r + (PW+1)'(acc && push) - (PW+1)'(cmd_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0; phase_r <= PH_IDLE; seen_r <= 1'b0;
      dec_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (acc) begin
        phase_r <= phase_nxt; seen_r <= seen_nxt; dec_r <= dec_nxt;
      end
      if (acc && push) wp_r <= (wp_r == PW'(QDEPTH-1)) ? '0 : wp_r + 1'b1;
      if (cmd_pop) rp_r <= (rp_r == PW'(QDEPTH-1)) ? '0 : rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && push) q_r[wp_r] <= c;
  end

  assign cmd = q_r[rp_r];
  assign cmd_valid = (cnt_r != '0);

  `ASC_ASSERT_IMPL(a_pop_valid, clk, rst_n, cmd_pop, cmd_valid)
  `ASC_ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= (PW+1)'(QDEPTH))
  `ASC_ASSERT_NEXT(a_start_ad, clk, rst_n, acc && in_ch.req_type == REQ_START,
                   phase_r == PH_AD)
endmodule
`default_nettype wire

/* design/asc_back.sv */
`default_nettype none
`include "ascon128_aead_engine_defines.svh"
module asc_back import asc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [63:0] key_hi,
  input  wire logic [63:0] key_lo,
  input  wire cmd_t        cmd,
  input  wire logic        cmd_valid,
  output logic             cmd_pop,
  asc_out_if.source        out_ch
);
  localparam logic [2:0] ST_IDLE = 3'd0, ST_PRE = 3'd1, ST_PERM = 3'd2,
                         ST_POST = 3'd3, ST_EMIT = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [319:0] s_r, s_nxt;
  logic [3:0] rnd_r, rnd_nxt;
  logic [1:0] nres_r, nres_nxt, ridx_r, ridx_nxt;
  cmd_t c_r, c_nxt;
  logic pre_r, pre_nxt;    // AD close pass pending
  logic [63:0] res_r, res_nxt;
  logic ov_r, ov_nxt;
  res_t o_r, o_nxt;
  logic [63:0] s0;
  logic [2:0] n;
  logic [63:0] cm;

  assign s0 = s_r[319:256];
  assign n = c_r.cnt;
  assign cm = top_mask(n);
  assign out_ch.valid = ov_r;
  assign out_ch.out_kind = o_r.kind;
  assign out_ch.out_data = o_r.data;
  assign out_ch.out_bytes = o_r.bytes;
  assign out_ch.tag_ok = o_r.ok;
  assign out_ch.last_result = o_r.last;

  always_comb begin
    st_nxt = st_r; s_nxt = s_r; rnd_nxt = rnd_r; nres_nxt = nres_r; ridx_nxt = ridx_r;
    c_nxt = c_r; pre_nxt = pre_r; res_nxt = res_r; ov_nxt = ov_r; o_nxt = o_r;
    cmd_pop = 1'b0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE: if (cmd_valid) begin
        cmd_pop = 1'b1; c_nxt = cmd; st_nxt = ST_PRE;
        pre_nxt = (cmd.op == OP_MSG || cmd.op == OP_MSGLAST) && cmd.close_ad;
      end
      ST_PRE: begin
        st_nxt = ST_PERM; rnd_nxt = 4'd6; nres_nxt = 2'd0; ridx_nxt = 2'd0;
        if (pre_r) begin
          pre_nxt = 1'b0;
          if (c_r.absorb) s_nxt[319:256] = s0 ^ pad_bit(3'd0);
          else begin
            // nothing absorbed: domain separation only, then the payload
            s_nxt[0] = s_r[0] ^ 1'b1; c_nxt.close_ad = 1'b0; st_nxt = ST_PRE;
          end
        end else begin
          unique case (c_r.op)
            OP_START: begin
              s_nxt = {INIT_VECTOR, key_hi, key_lo, c_r.wa, c_r.wb}; rnd_nxt = 4'd0;
            end
            OP_AD: s_nxt[319:256] = s0 ^ c_r.wa;
            OP_ADLAST: begin
              if (c_r.absorb) s_nxt[319:256] = s0 ^ (c_r.wa & cm) ^ pad_bit(n);
              else begin
                s_nxt[0] = s_r[0] ^ 1'b1; st_nxt = ST_IDLE;
              end
            end
            OP_MSG: begin
              res_nxt = s0 ^ c_r.wa;
              s_nxt[319:256] = c_r.dmode ? c_r.wa : s0 ^ c_r.wa;
              nres_nxt = 2'd1;
            end
            OP_MSGLAST: begin
              res_nxt = (s0 ^ c_r.wa) & cm;
              s_nxt[319:256] = (c_r.dmode ? ((s0 & ~cm) | (c_r.wa & cm))
                                          : (s0 ^ (c_r.wa & cm))) ^ pad_bit(n);
              s_nxt[255:192] = s_r[255:192] ^ key_hi;
              s_nxt[191:128] = s_r[191:128] ^ key_lo;
              rnd_nxt = 4'd0; nres_nxt = c_r.dmode ? 2'd1 : 2'd3;
            end
            default: begin
              st_nxt = ST_EMIT; nres_nxt = 2'd1;
            end
          endcase
        end
      end
      ST_PERM: begin
        s_nxt = ascon_round(s_r, rnd_r);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd11) st_nxt = ST_POST;
      end
      ST_POST: begin
        st_nxt = (nres_r != 2'd0) ? ST_EMIT : ST_IDLE;
        if (c_r.close_ad && (c_r.op == OP_MSG || c_r.op == OP_MSGLAST)) begin
          // AD close pass done: apply domain separation, then run payload
          s_nxt[0] = s_r[0] ^ 1'b1; c_nxt.close_ad = 1'b0; st_nxt = ST_PRE;
        end else begin
          if (c_r.op == OP_START || c_r.op == OP_MSGLAST) begin
            s_nxt[127:64] = s_r[127:64] ^ key_hi;
            s_nxt[63:0] = s_r[63:0] ^ key_lo;
          end
          if (c_r.op == OP_ADLAST) s_nxt[0] = s_r[0] ^ 1'b1;
        end
      end
      default: if (!ov_r || out_ch.ready) begin
        ov_nxt = 1'b1;
        o_nxt = '0;
        if (c_r.op == OP_TAG) begin
          o_nxt.kind = KIND_VER;
          o_nxt.ok = (c_r.wa == s_r[127:64]) && (c_r.wb == s_r[63:0]);
        end else if (ridx_r == 2'd0) begin
          o_nxt.kind = KIND_MSG; o_nxt.data = res_r;
          o_nxt.bytes = (c_r.op == OP_MSG) ? 4'd8 : {1'b0, n};
        end else begin
          o_nxt.kind = KIND_TAG; o_nxt.bytes = 4'd8;
          o_nxt.data = (ridx_r == 2'd1) ? s_r[127:64] : s_r[63:0];
        end
        o_nxt.last = (ridx_r + 2'd1 == nres_r);
        ridx_nxt = ridx_r + 2'd1;
        if (ridx_r + 2'd1 == nres_r) st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; s_r <= '0; ov_r <= 1'b0; pre_r <= 1'b0;
    end else begin
      st_r <= st_nxt; s_r <= s_nxt; ov_r <= ov_nxt; pre_r <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r <= rnd_nxt; nres_r <= nres_nxt; ridx_r <= ridx_nxt; c_r <= c_nxt;
    res_r <= res_nxt; o_r <= o_nxt;
  end

  `ASC_ASSERT_IMPL(a_pop_idle, clk, rst_n, cmd_pop, st_r == ST_IDLE)
  `ASC_ASSERT_NEXT(a_hold, clk, rst_n, ov_r && !out_ch.ready, ov_r && $stable(o_r))
  `ASC_ASSERT_IMPL(a_perm_rnd, clk, rst_n, st_r == ST_PERM, rnd_r <= 4'd11)
endmodule
`default_nettype wire

/* design/ascon128_aead_engine.sv */
// channel | dir | handshake   | payload
// in_     | in  | valid/ready | req_type decrypt_mode word_a word_b byte_count last_block
// out_    | out | valid/ready | out_kind out_data out_bytes tag_ok last_result
// cfg_    | in  | we only     | index (1 bit), 64-bit data
// One permutation round per cycle in the back end: a start or a final
// payload block runs all twelve rounds, other data blocks the last six,
// a tag item none; results are registered in the emit state after that.
// A payload block that closes AD first runs a pad pass (separation only if AD is empty).
// Synchronous active-low reset; the command queue lets the front accept
// while results wait on out_ready.
`default_nettype none
module ascon128_aead_engine import asc_pkg::*; #(
  parameter int unsigned QDEPTH = QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  asc_in_if.sink           in_ch,
  asc_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [63:0] key_hi_r, key_lo_r;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_KEY_HIGH) key_hi_r <= cfg_data;
      if (cfg_index == CFG_KEY_LOW) key_lo_r <= cfg_data;
    end
  end

  asc_front #(.QDEPTH(QDEPTH)) u_front (
    .clk, .rst_n, .in_ch, .cmd, .cmd_valid, .cmd_pop
  );

  asc_back u_back (
    .clk, .rst_n, .key_hi(key_hi_r), .key_lo(key_lo_r), .cmd, .cmd_valid, .cmd_pop,
    .out_ch
  );
endmodule
`default_nettype wire

/* verif/tb_ascon128_aead_engine.sv */
`default_nettype none
module tb_ascon128_aead_engine;
  import asc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ST_IDLE, ST_AD, ST_PAYLOAD, ST_TAGWAIT
  } eng_phase_e;

  typedef struct {
    logic [1:0]  req;
    logic        dmode;
    logic [63:0] wa;
    logic [63:0] wb;
    logic [3:0]  cnt;
    logic        last;
    bit          hold;       // wait for all results before presenting
    bit          true_tag;   // tag words taken from the predicted state
    logic [63:0] tag_flip;   // xor applied to the true tag lower word
  } blk_req_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [63:0] cfg_data;

  asc_in_if  in_if ();
  asc_out_if out_if ();

  ascon128_aead_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // predictor state
  logic [63:0] key_hi, key_lo;
  logic [63:0] sp [5];
  eng_phase_e  eng_phase;
  logic        dec_mode;
  logic        ad_absorbed;

  blk_req_t pending_q[$];
  res_t     expected_res_q[$];
  int       err_cnt;
  int       gen_cnt;
  bit       gap_en;
  bit       stall_en;

  function automatic logic [63:0] ror64(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] lead_mask(logic [2:0] n);
    return (n == 0) ? 64'd0 : (~64'd0 << (64 - 8 * n));
  endfunction

  function automatic logic [63:0] pad_word(logic [2:0] n);
    return 64'h80 << (56 - 8 * n);
  endfunction

  task automatic sponge_rounds(int n);
    logic [63:0] x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
    for (int r = 12 - n; r < 12; r++) begin
      x0 = sp[0]; x1 = sp[1]; x2 = sp[2]; x3 = sp[3]; x4 = sp[4];
      x2 ^= 64'(8'hf0 - 8'h0f * r);
      x0 ^= x4; x4 ^= x3; x2 ^= x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
      x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
      sp[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
      sp[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
      sp[2] = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
      sp[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
      sp[4] = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
    end
  endtask

  task automatic push_res(logic [1:0] kind, logic [63:0] data, logic [3:0] nb,
                          logic ok, logic lst);
    res_t r;
    r.kind = kind; r.data = data; r.bytes = nb; r.ok = ok; r.last = lst;
    expected_res_q.push_back(r);
  endtask

  task automatic predict_item(blk_req_t it);
    logic [2:0]  n;
    logic [63:0] m, res;
    n = (it.cnt > 7) ? 3'd7 : it.cnt[2:0];
    case (it.req)
      REQ_START: begin
        sp[0] = INIT_VECTOR; sp[1] = key_hi; sp[2] = key_lo;
        sp[3] = it.wa; sp[4] = it.wb;
        sponge_rounds(12);
        sp[3] ^= key_hi; sp[4] ^= key_lo;
        dec_mode = it.dmode;
        ad_absorbed = 1'b0;
        eng_phase = ST_AD;
      end
      REQ_AD: begin
        if (eng_phase == ST_AD) begin
          if (!it.last) begin
            sp[0] ^= it.wa;
            sponge_rounds(6);
            ad_absorbed = 1'b1;
          end else begin
            if (n != 0 || ad_absorbed) begin
              sp[0] ^= (it.wa & lead_mask(n)) ^ pad_word(n);
              sponge_rounds(6);
            end
            sp[4] ^= 64'd1;
            eng_phase = ST_PAYLOAD;
          end
        end
      end
      REQ_MSG: begin
        // payload closes an unterminated AD phase
        if (eng_phase == ST_AD) begin
          if (ad_absorbed) begin
            sp[0] ^= pad_word(0);
            sponge_rounds(6);
          end
          sp[4] ^= 64'd1;
          eng_phase = ST_PAYLOAD;
        end
        if (eng_phase == ST_PAYLOAD) begin
          if (!it.last) begin
            if (dec_mode) begin
              res = sp[0] ^ it.wa;
              sp[0] = it.wa;
            end else begin
              sp[0] ^= it.wa;
              res = sp[0];
            end
            sponge_rounds(6);
            push_res(KIND_MSG, res, 4'd8, 1'b0, 1'b1);
          end else begin
            m = lead_mask(n);
            if (dec_mode) begin
              res = (sp[0] ^ it.wa) & m;
              sp[0] = (sp[0] & ~m) | (it.wa & m);
            end else begin
              sp[0] ^= it.wa & m;
              res = sp[0] & m;
            end
            sp[0] ^= pad_word(n);
            sp[1] ^= key_hi; sp[2] ^= key_lo;
            sponge_rounds(12);
            sp[3] ^= key_hi; sp[4] ^= key_lo;
            if (dec_mode) begin
              eng_phase = ST_TAGWAIT;
              push_res(KIND_MSG, res, {1'b0, n}, 1'b0, 1'b1);
            end else begin
              eng_phase = ST_IDLE;
              push_res(KIND_MSG, res, {1'b0, n}, 1'b0, 1'b0);
              push_res(KIND_TAG, sp[3], 4'd8, 1'b0, 1'b0);
              push_res(KIND_TAG, sp[4], 4'd8, 1'b0, 1'b1);
            end
          end
        end
      end
      default: begin
        if (eng_phase == ST_TAGWAIT) begin
          eng_phase = ST_IDLE;
          push_res(KIND_VER, 64'd0, 4'd0, (it.wa == sp[3] && it.wb == sp[4]), 1'b1);
        end
      end
    endcase
  endtask

  task automatic add_req(logic [1:0] req, logic dm, logic [63:0] wa, logic [63:0] wb,
                         logic [3:0] cnt, logic lst);
    blk_req_t it;
    it.req = req; it.dmode = dm; it.wa = wa; it.wb = wb; it.cnt = cnt; it.last = lst;
    it.hold = ($urandom_range(0, 59) == 0);
    it.true_tag = 1'b0;
    it.tag_flip = '0;
    pending_q.push_back(it);
    gen_cnt++;
  endtask

  task automatic add_tag(bit good);
    blk_req_t it;
    it.req = REQ_TAG; it.dmode = $urandom_range(0, 1);
    it.wa = {$urandom, $urandom}; it.wb = {$urandom, $urandom};
    it.cnt = $urandom_range(0, 15); it.last = $urandom_range(0, 1);
    it.hold = 1'b0;
    it.true_tag = 1'b1;
    it.tag_flip = good ? 64'd0 : (64'd1 << $urandom_range(0, 63));
    if (!good && $urandom_range(0, 1)) it.true_tag = 1'b0;
    pending_q.push_back(it);
    gen_cnt++;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic add_noise();
    add_req($urandom_range(0, 3), $urandom_range(0, 1), rnd64(), rnd64(),
            $urandom_range(0, 15), $urandom_range(0, 1));
  endtask

  // one message with random content, now and then with a noise item inside
  task automatic add_message();
    logic dm;
    int   n_ad, n_pl;
    dm = $urandom_range(0, 1);
    n_ad = $urandom_range(0, 3);
    n_pl = $urandom_range(0, 3);
    add_req(REQ_START, dm, rnd64(), rnd64(), $urandom_range(0, 15), $urandom_range(0, 1));
    repeat (n_ad) add_req(REQ_AD, $urandom_range(0, 1), rnd64(), rnd64(),
                          $urandom_range(0, 15), 1'b0);
    if ($urandom_range(0, 3) != 0)
      add_req(REQ_AD, $urandom_range(0, 1), rnd64(), rnd64(), $urandom_range(0, 8), 1'b1);
    repeat (n_pl) add_req(REQ_MSG, $urandom_range(0, 1), rnd64(), rnd64(),
                          $urandom_range(0, 15), 1'b0);
    if ($urandom_range(0, 15) == 0) add_noise();
    add_req(REQ_MSG, $urandom_range(0, 1), rnd64(), rnd64(), $urandom_range(0, 8), 1'b1);
    if (dm) add_tag($urandom_range(0, 2) != 0);
  endtask

  // driver
  blk_req_t cur_req;
  bit       drv_busy;
  int       gap_left;

  initial begin
    in_if.valid = 1'b0; in_if.req_type = '0; in_if.decrypt_mode = 1'b0;
    in_if.word_a = '0; in_if.word_b = '0; in_if.byte_count = '0; in_if.last_block = 1'b0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    drv_busy = 1'b0; gap_left = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      drv_busy = 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_item(cur_req);
        drv_busy = 1'b0;
      end
      if (!drv_busy && pending_q.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending_q[0].hold || expected_res_q.size() == 0) begin
          cur_req = pending_q.pop_front();
          if (cur_req.true_tag) begin
            cur_req.wa = sp[3];
            cur_req.wb = sp[4] ^ cur_req.tag_flip;
          end
          drv_busy = 1'b1;
          gap_left = gap_en ? $urandom_range(0, 12) : 0;
        end
      end
      in_if.valid        <= drv_busy;
      in_if.req_type     <= cur_req.req;
      in_if.decrypt_mode <= cur_req.dmode;
      in_if.word_a       <= cur_req.wa;
      in_if.word_b       <= cur_req.wb;
      in_if.byte_count   <= cur_req.cnt;
      in_if.last_block   <= cur_req.last;
    end
  end

  // monitor
  int stall_left;

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_res_q.size() == 0) begin
          $error("unexpected result kind=%0d data=%h", out_if.out_kind, out_if.out_data);
          err_cnt++;
        end else begin
          want = expected_res_q.pop_front();
          if (out_if.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, got %0d", want.kind, out_if.out_kind);
            err_cnt++;
          end
          if (out_if.out_data !== want.data) begin
            $error("out_data: expected %h, got %h", want.data, out_if.out_data);
            err_cnt++;
          end
          if (out_if.out_bytes !== want.bytes) begin
            $error("out_bytes: expected %0d, got %0d", want.bytes, out_if.out_bytes);
            err_cnt++;
          end
          if (out_if.tag_ok !== want.ok) begin
            $error("tag_ok: expected %0d, got %0d", want.ok, out_if.tag_ok);
            err_cnt++;
          end
          if (out_if.last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, out_if.last_result);
            err_cnt++;
          end
        end
        stall_left = stall_en ? $urandom_range(0, 12) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() != 0 || drv_busy || expected_res_q.size() != 0)
      @(posedge clk);
    // start and AD items may still be in flight with no result to wait on
    repeat (80) @(posedge clk);
  endtask

  task automatic write_key(logic [63:0] hi, logic [63:0] lo);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_KEY_HIGH; cfg_data <= hi;
    @(posedge clk);
    cfg_index <= CFG_KEY_LOW; cfg_data <= lo;
    key_hi = hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    key_lo = lo;
  endtask

  initial begin
    logic [63:0] khi [5];
    logic [63:0] klo [5];
    key_hi = '0; key_lo = '0;
    foreach (sp[i]) sp[i] = '0;
    eng_phase = ST_IDLE; dec_mode = 1'b0; ad_absorbed = 1'b0;
    err_cnt = 0; gen_cnt = 0;
    gap_en = 1'b1; stall_en = 1'b1;
    khi[0] = '0;  klo[0] = ~64'd0;
    khi[1] = ~64'd0; klo[1] = ~64'd0;
    khi[2] = rnd64(); klo[2] = rnd64();
    khi[3] = ~64'd0; klo[3] = '0;
    khi[4] = rnd64(); klo[4] = rnd64();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // reset key of zero first
    add_req(REQ_TAG, 0, '0, '0, 0, 0);
    add_req(REQ_MSG, 0, ~64'd0, '0, 8, 1);
    add_req(REQ_AD, 1, ~64'd0, ~64'd0, 15, 1);
    add_req(REQ_START, 0, '0, '0, 0, 0);
    add_req(REQ_AD, 0, '0, '0, 0, 1);
    add_req(REQ_MSG, 0, '0, '0, 0, 1);
    add_req(REQ_START, 1, ~64'd0, ~64'd0, 15, 1);
    add_req(REQ_MSG, 0, rnd64(), '0, 3, 0);
    add_req(REQ_MSG, 0, ~64'd0, '0, 8, 1);
    add_req(REQ_MSG, 0, rnd64(), '0, 2, 1);
    add_req(REQ_AD, 0, rnd64(), '0, 2, 1);
    add_tag(1);
    add_req(REQ_START, 0, rnd64(), rnd64(), 0, 0);
    add_req(REQ_AD, 0, ~64'd0, '0, 8, 0);
    add_req(REQ_MSG, 1, ~64'd0, '0, 0, 0);
    add_req(REQ_AD, 0, rnd64(), '0, 3, 1);
    add_req(REQ_MSG, 0, ~64'd0, '0, 7, 1);
    add_req(REQ_START, 1, rnd64(), rnd64(), 0, 0);
    add_req(REQ_START, 0, rnd64(), rnd64(), 0, 0);
    add_req(REQ_AD, 0, rnd64(), '0, 15, 1);
    add_req(REQ_MSG, 0, rnd64(), '0, 5, 1);
    add_req(REQ_START, 1, rnd64(), rnd64(), 0, 0);
    add_req(REQ_MSG, 0, rnd64(), '0, 4, 1);
    add_tag(0);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      write_key(khi[ph], klo[ph]);
      gap_en = (ph != 2);
      stall_en = (ph != 3);
      if (ph == 1) begin
        add_message();
        pending_q[0].hold = 1'b1;
      end
      while (gen_cnt < 24 + (ph + 1) * 86) begin
        if ($urandom_range(0, 7) == 0) add_noise();
        else add_message();
      end
      wait_drained();
    end
    if (err_cnt == 0) begin
      $display("tb_ascon128_aead_engine: PASS");
    end else begin
      $display("tb_ascon128_aead_engine: FAIL");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("tb_ascon128_aead_engine: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
